[rtl/pllr_pkg.sv]
// Shared types, constants and codes for the PLL rate round and recalc unit.
package pllr_pkg;

   localparam int RATE_W = 40;
   localparam int IN_W   = 32;
   localparam int CFG_W  = 32;
   localparam int ADDR_W = 5;
   localparam int FRAC_W = 16;
   localparam int FACT_W = 18;
   localparam int DIVN_W = 50;
   localparam int DIVD_W = 32;
   localparam int DIVC_W = $clog2(DIVN_W + 1);

   localparam logic [1:0] KIND_ANALOG = 2'd0;
   localparam logic [1:0] KIND_FIXED  = 2'd2;

   localparam logic REQ_RECALC = 1'b1;

   localparam logic [2:0] REG_PLL_KIND = 3'd0;
   localparam logic [2:0] REG_FIXED_HZ = 3'd1;
   localparam logic [2:0] REG_MULT     = 3'd2;
   localparam logic [2:0] REG_DIV      = 3'd3;
   localparam logic [2:0] REG_SD       = 3'd4;

   localparam logic [16:0] SD_RESET = 17'h10000;

   typedef struct packed {
      logic [1:0]  pll_kind;
      logic [31:0] fixed_hz;
      logic [15:0] mult_setting;
      logic [7:0]  div_setting;
      logic [16:0] sd_divisor;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PROD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ADJUST,
      ST_SEARCH,
      ST_DRAIN,
      ST_RESULT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      RES_FIXED,
      RES_SAT,
      RES_ZERO,
      RES_QUOT,
      RES_ROUND,
      RES_BEST
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        prod_load;
      logic        div_start;
      logic        adjust_load;
      logic        search_start;
      logic        search_feed;
      logic        out_load;
      res_sel_type res_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] pll_kind;
      logic       recalc;
      logic       parent_zero;
      logic       sd_zero;
      logic       div_busy;
      logic       search_last;
      logic       pipe_busy;
   } dp_status_type;

endpackage

[rtl/pllr_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module pllr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pllr_pkg::DIVN_W-1:0] num,
   input  logic [pllr_pkg::DIVD_W-1:0] den,
   output logic                       busy,
   output logic [pllr_pkg::DIVN_W-1:0] quot,
   output logic [pllr_pkg::DIVD_W-1:0] rem
);
   import pllr_pkg::*;

   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] den_ff, den_in;
   logic [DIVN_W-1:0] work_ff, work_in;
   logic [DIVD_W:0]   trial;
   logic [DIVD_W:0]   diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, work_ff[DIVN_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      work_in = work_ff;
      if (start) begin
         cnt_in  = DIVC_W'(DIVN_W);
         rem_in  = '0;
         den_in  = den;
         work_in = num;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = fits ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
         work_in = {work_ff[DIVN_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      work_ff <= work_in;
   end

   assign busy = cnt_ff != '0;
   assign quot = work_ff;
   assign rem  = rem_ff;

endmodule

[rtl/pllr_spipe.sv]
// Pipelined divider by a small divisor, one quotient bit per stage.
module pllr_spipe #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic             busy
);
   logic             valid_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   logic [NUM_W-1:0] work_ff  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic             prev_valid;
      logic [DEN_W-1:0] prev_rem;
      logic [DEN_W-1:0] prev_den;
      logic [NUM_W-1:0] prev_work;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             fits;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] work_in;

      if (s == 0) begin : g_head
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_den   = in_den;
         assign prev_work  = in_num;
      end else begin : g_link
         assign prev_valid = valid_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_den   = den_ff[s-1];
         assign prev_work  = work_ff[s-1];
      end

      always_comb begin
         trial   = {prev_rem, prev_work[NUM_W-1]};
         diff    = trial - {1'b0, prev_den};
         fits    = trial >= {1'b0, prev_den};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         work_in = {prev_work[NUM_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= prev_valid;
         end
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= prev_den;
         work_ff[s] <= work_in;
      end
   end

   always_comb begin
      busy = 1'b0;
      for (int i = 0; i < NUM_W; i++) begin
         busy = busy | valid_ff[i];
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = work_ff[NUM_W-1];

endmodule

[rtl/pllr_datapath.sv]
// Datapath: request capture, product, dividers, candidate search and result register.
module pllr_datapath #(
   parameter int SEARCH_MULT_MAX = 255,
   parameter int SEARCH_DIV_MAX  = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pllr_pkg::ctrl_cmd_type        cmd,
   output pllr_pkg::dp_status_type       status,
   input  pllr_pkg::cfg_type             cfg,
   input  logic                          req_type,
   input  logic [pllr_pkg::IN_W-1:0]     req_target_rate,
   input  logic [pllr_pkg::IN_W-1:0]     req_parent_rate,
   output logic [pllr_pkg::RATE_W-1:0]   rate_out,
   output logic                          saturated
);
   import pllr_pkg::*;

   localparam int MW = $clog2(SEARCH_MULT_MAX + 1);
   localparam int DW = $clog2(SEARCH_DIV_MAX + 1);
   localparam int NW = IN_W + MW;

   logic              type_ff;
   logic [IN_W-1:0]   target_ff;
   logic [IN_W-1:0]   parent_ff;
   logic [DIVN_W-1:0] prod_ff, prod_in;
   logic [47:0]       base_ff, base_in;
   logic              inc_ff, inc_in;
   logic [MW-1:0]     mul_ff;
   logic [DW-1:0]     dv_ff;
   logic [NW-1:0]     sprod_ff;
   logic [NW-1:0]     best_ff;
   logic [NW-1:0]     best_err_ff;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              sat_ff, sat_in;

   logic              recalc;
   logic              analog;
   logic [FACT_W-1:0] factor;
   logic [8:0]        div_plus;
   logic [DIVN_W-1:0] div_num;
   logic [DIVD_W-1:0] div_den;
   logic              div_busy;
   logic [DIVN_W-1:0] div_quot;
   logic [DIVD_W-1:0] div_rem;
   logic [48:0]       round_sum;
   logic              pipe_valid;
   logic              pipe_busy;
   logic [NW-1:0]     cand;
   logic [NW-1:0]     target_n;
   logic [NW-1:0]     err;
   logic              search_last;

   assign recalc   = type_ff == REQ_RECALC;
   assign analog   = cfg.pll_kind == KIND_ANALOG;
   assign div_plus = {1'b0, cfg.div_setting} + 9'd1;

   always_comb begin
      if (analog) begin
         factor = {2'b00, cfg.mult_setting} + FACT_W'(1);
      end else begin
         factor = {1'b0, cfg.sd_divisor} + {2'b00, cfg.mult_setting};
      end
      prod_in = DIVN_W'(parent_ff) * DIVN_W'(factor);
   end

   // Recalc divides the product; a digital round divides the target scaled by 2^16.
   always_comb begin
      if (recalc) begin
         div_num = prod_ff;
         div_den = analog ? {23'd0, div_plus} : {15'd0, cfg.sd_divisor};
      end else begin
         div_num = {2'b00, target_ff, 16'd0};
         div_den = parent_ff;
      end
   end

   pllr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // q*parent equals the scaled target less the remainder, plus parent when rounding up.
   assign base_in   = {target_ff, 16'd0} - {16'd0, div_rem};
   assign inc_in    = div_rem > {1'b0, parent_ff[IN_W-1:1]};
   assign round_sum = {1'b0, base_ff} + (inc_ff ? {17'd0, parent_ff} : 49'd0);

   assign search_last = (mul_ff == MW'(SEARCH_MULT_MAX)) && (dv_ff == DW'(SEARCH_DIV_MAX));

   pllr_spipe #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_spipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.search_feed),
      .in_num    (sprod_ff),
      .in_den    (dv_ff),
      .out_valid (pipe_valid),
      .out_quot  (cand),
      .busy      (pipe_busy)
   );

   assign target_n = NW'(target_ff);
   assign err      = (cand > target_n) ? cand - target_n : target_n - cand;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff   <= req_type;
         target_ff <= req_target_rate;
         parent_ff <= req_parent_rate;
      end
      if (cmd.prod_load) begin
         prod_ff <= prod_in;
      end
      if (cmd.adjust_load) begin
         base_ff <= base_in;
         inc_ff  <= inc_in;
      end
      // Walk dividers inside multipliers; the product grows by parent per row.
      if (cmd.search_start) begin
         mul_ff   <= MW'(1);
         dv_ff    <= DW'(1);
         sprod_ff <= NW'(parent_ff);
      end else if (cmd.search_feed) begin
         if (dv_ff == DW'(SEARCH_DIV_MAX)) begin
            dv_ff    <= DW'(1);
            mul_ff   <= mul_ff + 1'b1;
            sprod_ff <= sprod_ff + NW'(parent_ff);
         end else begin
            dv_ff <= dv_ff + 1'b1;
         end
      end
      // Replace the best only on a strictly smaller error.
      if (cmd.search_start) begin
         best_ff     <= '0;
         best_err_ff <= target_n;
      end else if (pipe_valid && (err < best_err_ff)) begin
         best_ff     <= cand;
         best_err_ff <= err;
      end
      if (cmd.out_load) begin
         rate_ff <= rate_in;
         sat_ff  <= sat_in;
      end
   end

   always_comb begin
      case (cmd.res_sel)
         RES_FIXED: begin
            rate_in = {8'd0, cfg.fixed_hz};
            sat_in  = 1'b0;
         end
         RES_SAT: begin
            rate_in = '1;
            sat_in  = 1'b1;
         end
         RES_ZERO: begin
            rate_in = '0;
            sat_in  = 1'b0;
         end
         RES_QUOT: begin
            if (div_quot[DIVN_W-1:RATE_W] != '0) begin
               rate_in = '1;
               sat_in  = 1'b1;
            end else begin
               rate_in = div_quot[RATE_W-1:0];
               sat_in  = 1'b0;
            end
         end
         RES_ROUND: begin
            rate_in = {7'd0, round_sum[48:FRAC_W]};
            sat_in  = 1'b0;
         end
         RES_BEST: begin
            rate_in = RATE_W'(best_ff);
            sat_in  = 1'b0;
         end
         default: begin
            rate_in = '0;
            sat_in  = 1'b0;
         end
      endcase
   end

   always_comb begin
      status.pll_kind    = cfg.pll_kind;
      status.recalc      = recalc;
      status.parent_zero = parent_ff == '0;
      status.sd_zero     = cfg.sd_divisor == '0;
      status.div_busy    = div_busy;
      status.search_last = search_last;
      status.pipe_busy   = pipe_busy;
   end

   assign rate_out  = rate_ff;
   assign saturated = sat_ff;

endmodule

[rtl/pllr_ctrl.sv]
// Controller: sequences each request through the datapath and owns the result valid.
module pllr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  pllr_pkg::dp_status_type status,
   output pllr_pkg::ctrl_cmd_type  cmd
);
   import pllr_pkg::*;

   ctrl_state_type state_ff, state_in;
   res_sel_type    res_sel_ff, res_sel_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           analog;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign analog   = status.pll_kind == KIND_ANALOG;

   always_comb begin
      state_in   = state_ff;
      res_sel_in = res_sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.pll_kind == KIND_FIXED) begin
               state_in   = ST_RESULT;
               res_sel_in = RES_FIXED;
            end else if (status.recalc) begin
               if (!analog && status.sd_zero) begin
                  state_in   = ST_RESULT;
                  res_sel_in = RES_SAT;
               end else begin
                  state_in   = ST_PROD;
                  res_sel_in = RES_QUOT;
               end
            end else if (analog) begin
               state_in   = ST_SEARCH;
               res_sel_in = RES_BEST;
            end else if (status.parent_zero) begin
               state_in   = ST_RESULT;
               res_sel_in = RES_ZERO;
            end else begin
               state_in   = ST_DIV_START;
               res_sel_in = RES_ROUND;
            end
         end
         ST_PROD: begin
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = status.recalc ? ST_RESULT : ST_ADJUST;
            end
         end
         ST_ADJUST: begin
            state_in = ST_RESULT;
         end
         ST_SEARCH: begin
            if (status.search_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.res_sel = res_sel_ff;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECIDE: begin
            cmd.search_start = 1'b1;
         end
         ST_PROD: begin
            cmd.prod_load = 1'b1;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         ST_ADJUST: begin
            cmd.adjust_load = 1'b1;
         end
         ST_SEARCH: begin
            cmd.search_feed = 1'b1;
         end
         ST_RESULT: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Hold the result until taken; a fresh load may replace one taken this cycle.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_sel_ff   <= RES_FIXED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_sel_ff   <= res_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/pll_rate_round_and_recalc_unit.sv]
// Top level of the PLL rate round and recalc unit: register file and block wiring.
//
// Requests arrive on the req_ channel (valid/stall) and each yields exactly one
// transaction on the rsp_ channel: the rate in Hz and a saturation flag.
// Settings are written over the APB-style port (psel/penable/pwrite, pready
// always high); register i sits at byte address 4*i. The user must write
// settings only while the block is idle; the block does not enforce this.
// One request is worked on at a time; req_stall is low only while idle.
// Path from an accepted request to the result:
//   fixed kind, zero divisor, or zero parent on a digital round: straight to the result
//   recalc and digital round: through the 50-step serial divider
//   analog round: every multiplier and divider pair, one candidate a cycle into
//   a pipelined small-divisor divider whose depth is the candidate width.
// The result sits in an output register: while the receiver stalls it holds,
// and the next request is already accepted; a finished request waits for it.
// Reset clears the controller, the pipelines and the settings registers to
// their defaults (analog kind, sd_divisor 65536); no clearing pass is needed.
module pll_rate_round_and_recalc_unit #(
   parameter int SEARCH_MULT_MAX = 255,
   parameter int SEARCH_DIV_MAX  = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [pllr_pkg::IN_W-1:0]     req_target_rate,
   input  logic [pllr_pkg::IN_W-1:0]     req_parent_rate,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pllr_pkg::RATE_W-1:0]   rsp_rate_out,
   output logic                          rsp_saturated,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pllr_pkg::ADDR_W-1:0]   paddr,
   input  logic [pllr_pkg::CFG_W-1:0]    pwdata,
   output logic [pllr_pkg::CFG_W-1:0]    prdata,
   output logic                          pready
);
   import pllr_pkg::*;

   cfg_type       cfg_ff;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          cfg_write;
   logic [2:0]    reg_idx;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pll_kind     <= KIND_ANALOG;
         cfg_ff.fixed_hz     <= '0;
         cfg_ff.mult_setting <= '0;
         cfg_ff.div_setting  <= '0;
         cfg_ff.sd_divisor   <= SD_RESET;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_PLL_KIND: cfg_ff.pll_kind     <= pwdata[1:0];
            REG_FIXED_HZ: cfg_ff.fixed_hz     <= pwdata;
            REG_MULT:     cfg_ff.mult_setting <= pwdata[15:0];
            REG_DIV:      cfg_ff.div_setting  <= pwdata[7:0];
            REG_SD:       cfg_ff.sd_divisor   <= pwdata[16:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PLL_KIND: prdata = {30'd0, cfg_ff.pll_kind};
         REG_FIXED_HZ: prdata = cfg_ff.fixed_hz;
         REG_MULT:     prdata = {16'd0, cfg_ff.mult_setting};
         REG_DIV:      prdata = {24'd0, cfg_ff.div_setting};
         REG_SD:       prdata = {15'd0, cfg_ff.sd_divisor};
         default:      prdata = '0;
      endcase
   end

   pllr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pllr_datapath #(
      .SEARCH_MULT_MAX (SEARCH_MULT_MAX),
      .SEARCH_DIV_MAX  (SEARCH_DIV_MAX)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg_ff),
      .req_type        (req_type),
      .req_target_rate (req_target_rate),
      .req_parent_rate (req_parent_rate),
      .rate_out        (rsp_rate_out),
      .saturated       (rsp_saturated)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request channel open right after an accepted transaction");

   a_sat_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_rate_out == '1))
      else $error("saturated result is not all ones");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a request in progress");

endmodule

[test/pll_rate_checker.sv]
// Checker for the PLL rate unit: predicts each response and compares it field by field.
`timescale 1ns / 1ps
module pll_rate_checker #(
   parameter int SEARCH_MULT_MAX = 255,
   parameter int SEARCH_DIV_MAX  = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_type,
   input  logic [pllr_pkg::IN_W-1:0]     req_target_rate,
   input  logic [pllr_pkg::IN_W-1:0]     req_parent_rate,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [pllr_pkg::RATE_W-1:0]   rsp_rate_out,
   input  logic                          rsp_saturated,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          pready,
   input  logic [pllr_pkg::ADDR_W-1:0]   paddr,
   input  logic [pllr_pkg::CFG_W-1:0]    pwdata,
   input  logic                          run_done,
   output int                            fail_count
);
   import pllr_pkg::*;

   localparam logic [63:0] RATE_MAX = 64'h0000_00FF_FFFF_FFFF;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic              sat;
   } rate_result_type;

   cfg_type         settings;
   rate_result_type expected_rates[$];
   logic            leftover_checked;

   // Exhaustive multiplier/divider search; only a strictly smaller error wins.
   function automatic logic [63:0] analog_best(input logic [63:0] target, parent);
      logic [63:0] best_err, best, cand, err;
      best_err = target;
      best     = '0;
      for (int mul = 1; mul <= SEARCH_MULT_MAX; mul++) begin
         for (int dv = 1; dv <= SEARCH_DIV_MAX; dv++) begin
            cand = (parent * 64'(mul)) / 64'(dv);
            err  = (cand > target) ? cand - target : target - cand;
            if (err < best_err) begin
               best_err = err;
               best     = cand;
            end
         end
      end
      return best;
   endfunction

   // Quantise to steps of parent/65536, ties rounding down.
   function automatic logic [63:0] digital_nearest(input logic [63:0] target, parent);
      logic [63:0] scaled, q, r;
      if (parent == 0)
         return '0;
      scaled = target << FRAC_W;
      q      = scaled / parent;
      r      = scaled % parent;
      if (r > parent / 2)
         q = q + 1;
      return (q * parent) >> FRAC_W;
   endfunction

   function automatic rate_result_type predict_rate(input logic recalc,
                                                    input logic [63:0] target, parent,
                                                    input cfg_type cfg);
      logic [63:0]     rate;
      logic            sat;
      rate_result_type res;
      sat = 1'b0;
      if (cfg.pll_kind == KIND_FIXED) begin
         rate = 64'(cfg.fixed_hz);
      end else if (recalc == REQ_RECALC) begin
         if (cfg.pll_kind == KIND_ANALOG) begin
            rate = (parent * (64'(cfg.mult_setting) + 64'd1)) / (64'(cfg.div_setting) + 64'd1);
         end else if (cfg.sd_divisor == 0) begin
            rate = '0;
            sat  = 1'b1;
         end else begin
            rate = (parent * (64'(cfg.sd_divisor) + 64'(cfg.mult_setting)))
                   / 64'(cfg.sd_divisor);
         end
      end else if (cfg.pll_kind == KIND_ANALOG) begin
         rate = analog_best(target, parent);
      end else begin
         rate = digital_nearest(target, parent);
      end
      if (sat || rate > RATE_MAX) begin
         res.rate = '1;
         res.sat  = 1'b1;
      end else begin
         res.rate = rate[RATE_W-1:0];
         res.sat  = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rate_result_type want;
      if (reset) begin
         settings.pll_kind     = KIND_ANALOG;
         settings.fixed_hz     = '0;
         settings.mult_setting = '0;
         settings.div_setting  = '0;
         settings.sd_divisor   = SD_RESET;
         expected_rates.delete();
         fail_count       = 0;
         leftover_checked = 1'b0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_PLL_KIND: settings.pll_kind     = pwdata[1:0];
               REG_FIXED_HZ: settings.fixed_hz     = pwdata[31:0];
               REG_MULT:     settings.mult_setting = pwdata[15:0];
               REG_DIV:      settings.div_setting  = pwdata[7:0];
               REG_SD:       settings.sd_divisor   = pwdata[16:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_rates.push_back(predict_rate(req_type, 64'(req_target_rate),
                                                  64'(req_parent_rate), settings));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rates.size() == 0) begin
               $error("response with no request outstanding: rate_out %0d saturated %0d",
                      rsp_rate_out, rsp_saturated);
               fail_count++;
            end else begin
               want = expected_rates.pop_front();
               if (rsp_rate_out !== want.rate) begin
                  $error("rate_out mismatch: expected %0d, actual %0d",
                         want.rate, rsp_rate_out);
                  fail_count++;
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated mismatch: expected %0d, actual %0d",
                         want.sat, rsp_saturated);
                  fail_count++;
               end
            end
         end
         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_rates.size() != 0) begin
               $error("%0d responses never arrived", expected_rates.size());
               fail_count += expected_rates.size();
            end
         end
      end
   end

endmodule

[test/pll_rate_round_and_recalc_unit_tb.sv]
// Testbench top for the PLL rate unit: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module pll_rate_round_and_recalc_unit_tb;
   import pllr_pkg::*;

   localparam int MULT_MAX     = 255;
   localparam int DIV_MAX      = 15;
   localparam int RANDOM_ITEMS = 150;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 4000;
   localparam int CYCLE_LIMIT  = 4_000_000;

   localparam logic       REQ_ROUND        = 1'b0;
   localparam logic [1:0] KIND_DIGITAL     = 2'd1;
   localparam logic [1:0] KIND_DIGITAL_ALT = 2'd3;
   localparam logic [2:0] REG_SPARE        = 3'd5;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_type;
   logic [IN_W-1:0]     req_target_rate;
   logic [IN_W-1:0]     req_parent_rate;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [RATE_W-1:0]   rsp_rate_out;
   logic                rsp_saturated;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [CFG_W-1:0]    pwdata;
   logic [CFG_W-1:0]    prdata;
   logic                pready;

   logic       run_done  = 1'b0;
   logic       hold_req  = 1'b0;
   logic       hold_done = 1'b0;
   logic [1:0] cur_kind  = KIND_ANALOG;
   int         fail_count;
   int         n_sent = 0, n_recv = 0, cycle_count = 0;
   int         n_search = 0, n_quant = 0, n_recalc = 0, n_fixed = 0, n_settings = 0;

   always #6 clock = ~clock;

   pll_rate_round_and_recalc_unit #(
      .SEARCH_MULT_MAX(MULT_MAX),
      .SEARCH_DIV_MAX (DIV_MAX)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_target_rate(req_target_rate),
      .req_parent_rate(req_parent_rate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rate_out   (rsp_rate_out),
      .rsp_saturated  (rsp_saturated),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   pll_rate_checker #(
      .SEARCH_MULT_MAX(MULT_MAX),
      .SEARCH_DIV_MAX (DIV_MAX)
   ) rate_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_target_rate(req_target_rate),
      .req_parent_rate(req_parent_rate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rate_out   (rsp_rate_out),
      .rsp_saturated  (rsp_saturated),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .run_done       (run_done),
      .fail_count     (fail_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles without finishing", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side: random stall runs, plus one long hold-off on request.
   initial begin : rsp_side
      int   run_left;
      logic stall_now;
      run_left  = 0;
      stall_now = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            n_recv++;
         if (hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done <= 1'b1;
            run_left = 0;
         end else begin
            if (run_left == 0) begin
               stall_now = ($urandom_range(0, 99) < 35);
               if (stall_now)
                  run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                         : $urandom_range(1, 3);
               else
                  run_left = $urandom_range(1, 30);
            end
            rsp_stall <= stall_now;
            run_left--;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom_range(1, 1000);
         3: return $urandom >> $urandom_range(1, 31);
         default: return $urandom;
      endcase
   endfunction

   // Target close to parent*mul/dv, with mul and dv reaching a little past the search range.
   function automatic logic [31:0] near_multiple(input logic [31:0] parent);
      logic [63:0] t;
      t = (64'(parent) * 64'($urandom_range(1, MULT_MAX + 20)))
          / 64'($urandom_range(1, DIV_MAX + 1));
      return t[31:0] + 32'($urandom_range(0, 7));
   endfunction

   task automatic send_item(input logic recalc, input logic [31:0] target, parent,
                            input bit burst);
      int gap;
      req_valid       <= 1'b1;
      req_type        <= recalc;
      req_target_rate <= target;
      req_parent_rate <= parent;
      do @(posedge clock); while (req_stall);
      n_sent++;
      if (cur_kind == KIND_FIXED)
         n_fixed++;
      else if (recalc == REQ_RECALC)
         n_recalc++;
      else if (cur_kind == KIND_ANALOG)
         n_search++;
      else
         n_quant++;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid       <= 1'b0;
         req_type        <= 1'($urandom);
         req_target_rate <= $urandom;
         req_parent_rate <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (n_recv != n_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Upper data bits beyond each register's width are passed through as given.
   task automatic load_settings(input logic [1:0] kind,
                                input logic [31:0] fixed, mult, div, sd);
      logic [31:0] kind_word;
      kind_word      = $urandom;
      kind_word[1:0] = kind;
      write_reg(REG_PLL_KIND, kind_word);
      write_reg(REG_FIXED_HZ, fixed);
      write_reg(REG_MULT, mult);
      write_reg(REG_DIV, div);
      write_reg(REG_SD, sd);
      write_reg(REG_SPARE, $urandom);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_kind = kind;
      n_settings++;
   endtask

   initial begin : stimulus
      logic [1:0]  kind;
      logic [31:0] fx, m, d, sd, p, tgt;
      logic        recalc;
      int          n, phase, n_random;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= 1'b0;
      req_target_rate <= '0;
      req_parent_rate <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: analog, unity multiplier and divider
      send_item(REQ_RECALC, '0, '1, 0);
      send_item(REQ_RECALC, 32'd77, '0, 0);
      send_item(REQ_ROUND, '0, 32'd1000, 0);
      send_item(REQ_ROUND, '1, '1, 0);
      send_item(REQ_ROUND, 32'd12345, '0, 0);
      send_item(REQ_ROUND, 32'd1000, 32'd300, 0);
      wait_for_results();

      // analog recalc at the multiplier and divider extremes
      load_settings(KIND_ANALOG, '0, 32'h0000_FFFF, '0, 32'(SD_RESET));
      send_item(REQ_RECALC, '0, '1, 0);
      wait_for_results();
      load_settings(KIND_ANALOG, '0, '0, 32'h0000_00FF, 32'(SD_RESET));
      send_item(REQ_RECALC, '0, '1, 0);
      wait_for_results();

      // digital: overflow on recalc, zero parent and rounding either side of half a step
      load_settings(KIND_DIGITAL, '0, 32'h0000_FFFF, 32'h0000_00FF, 32'd1);
      send_item(REQ_RECALC, '0, '1, 0);
      send_item(REQ_ROUND, 32'd5, '0, 0);
      send_item(REQ_ROUND, 32'd1, 32'd3, 0);
      send_item(REQ_ROUND, 32'd2, 32'd3, 0);
      send_item(REQ_ROUND, '1, 32'd1, 0);
      send_item(REQ_ROUND, '0, '1, 0);
      wait_for_results();

      // zero sigma-delta divisor
      load_settings(KIND_DIGITAL, '0, 32'd3, '0, '0);
      send_item(REQ_RECALC, '0, 32'd1000, 0);
      send_item(REQ_ROUND, '1, 32'd1000, 0);
      wait_for_results();

      // the unnamed fourth kind acts as digital
      load_settings(KIND_DIGITAL_ALT, '0, '0, '0, 32'h0001_FFFF);
      send_item(REQ_RECALC, '0, '1, 0);
      send_item(REQ_ROUND, 32'd99999, 32'd48000000, 0);
      wait_for_results();

      load_settings(KIND_FIXED, '1, '1, '1, '1);
      send_item(REQ_RECALC, '1, '1, 0);
      send_item(REQ_ROUND, '0, '0, 0);
      wait_for_results();

      phase    = 0;
      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         if (phase == 2) begin
            // fast fixed-kind requests against a long response hold-off
            load_settings(KIND_FIXED, pick_rate(), $urandom, $urandom, $urandom);
            hold_req <= 1'b1;
            repeat (12) begin
               send_item(1'($urandom), pick_rate(), pick_rate(), 1);
               n_random++;
            end
         end else begin
            kind = 2'($urandom_range(0, 3));
            fx   = pick_rate();
            m    = $urandom;
            case ($urandom_range(0, 3))
               0: m[15:0] = '0;
               1: m[15:0] = '1;
               default: ;
            endcase
            d = $urandom;
            case ($urandom_range(0, 3))
               0: d[7:0] = '0;
               1: d[7:0] = '1;
               default: ;
            endcase
            sd = $urandom;
            case ($urandom_range(0, 7))
               0: sd[16:0] = '0;
               1: sd[16:0] = 17'd1;
               2: sd[16:0] = SD_RESET;
               3: sd[16:0] = '1;
               4: sd[16:0] = 17'($urandom_range(1, 16));
               default: ;
            endcase
            load_settings(kind, fx, m, d, sd);
            n = $urandom_range(6, 18);
            repeat (n) begin
               if (kind == KIND_ANALOG)
                  recalc = ($urandom_range(0, 9) < 7);
               else
                  recalc = 1'($urandom);
               p = pick_rate();
               if (!recalc && kind == KIND_ANALOG && $urandom_range(0, 1) == 1)
                  tgt = near_multiple(p);
               else
                  tgt = pick_rate();
               send_item(recalc, tgt, p, 0);
               n_random++;
            end
         end
         wait_for_results();
         phase++;
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      run_done <= 1'b1;
      @(posedge clock);
      @(posedge clock);
      $display("covered %0d requests: %0d searches, %0d roundings, %0d recalcs, %0d fixed",
               n_sent, n_search, n_quant, n_recalc, n_fixed);
      $display("over %0d register settings, with one long response hold-off", n_settings);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
